>>> hdl/nfc_pkg.sv
// ----------------------------------------------------------------------------
// nfc_pkg: shared types and constants of the normal information frame builder
// Payload structs of both channels, the job handed from the front end to the
// sequencer, and the fixed frame bytes.
// ----------------------------------------------------------------------------
package nfc_pkg;

  // input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_frame;
    logic [7:0] payload_length;
  } nfc_in_t;

  // result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       status;
    logic       frame_end;
    logic       run_last;
  } nfc_out_t;

  // position of a result byte within a frame
  typedef enum logic [3:0] {
    POS_PRE0,
    POS_PRE1,
    POS_START,
    POS_LEN,
    POS_LCS,
    POS_TFI,
    POS_DATA,
    POS_DCS,
    POS_POST,
    POS_ERR
  } nfc_pos_e;

  // run of result bytes caused by one input item
  typedef struct packed {
    nfc_pos_e   first_pos;
    nfc_pos_e   last_pos;
    logic [7:0] data_byte;
    logic [7:0] len_byte;
    logic [7:0] tfi;
    logic [7:0] dcs;
  } nfc_job_t;

  localparam logic [7:0] TFI_RESET  = 8'hD4;
  localparam logic [7:0] PREAMBLE   = 8'h00;
  localparam logic [7:0] START_CODE = 8'hFF;
  localparam logic [7:0] POSTAMBLE  = 8'h00;
  localparam logic [7:0] ERR_BYTE   = 8'h00;

endpackage

>>> hdl/nfc_fb_front.sv
// ----------------------------------------------------------------------------
// nfc_fb_front: frame state and job builder
// Holds the frame state and the TFI register, and turns each accepted input
// item that causes results into a job describing the run of result bytes.
// ----------------------------------------------------------------------------
module nfc_fb_front import nfc_pkg::*; #(
  parameter int MaxPayload = 254
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  nfc_in_t    in_data_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       job_ready_i,
  output logic       job_valid_o,
  output nfc_job_t   job_o
);

  logic [7:0] tfi_q;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] checksum_q, checksum_d;
  logic       drop_q, drop_d;
  logic       in_acc;
  logic       has_job;
  logic [7:0] len_eff;
  logic       too_long;

  assign in_acc   = in_valid_i && job_ready_i;
  assign len_eff  = (in_data_i.payload_length == 8'd0) ? 8'd1 : in_data_i.payload_length;
  assign too_long = len_eff > 8'(MaxPayload);

  // next frame state and job for the incoming item
  always_comb begin
    bytes_left_d    = bytes_left_q;
    checksum_d      = checksum_q;
    drop_d          = drop_q;
    has_job         = 1'b0;
    job_o           = '0;
    job_o.first_pos = POS_DATA;
    job_o.last_pos  = POS_DATA;
    job_o.data_byte = in_data_i.data_byte;
    job_o.len_byte  = len_eff + 8'd1;
    job_o.tfi       = tfi_q;
    if (in_data_i.start_of_frame) begin
      has_job = 1'b1;
      if (too_long) begin
        bytes_left_d    = 8'd0;
        checksum_d      = 8'd0;
        drop_d          = 1'b1;
        job_o.first_pos = POS_ERR;
        job_o.last_pos  = POS_ERR;
      end else begin
        bytes_left_d    = len_eff - 8'd1;
        checksum_d      = 8'd0 - tfi_q - in_data_i.data_byte;
        drop_d          = 1'b0;
        job_o.first_pos = POS_PRE0;
        job_o.last_pos  = (bytes_left_d == 8'd0) ? POS_POST : POS_DATA;
      end
    end else if (!drop_q && bytes_left_q != 8'd0) begin
      has_job        = 1'b1;
      bytes_left_d   = bytes_left_q - 8'd1;
      checksum_d     = checksum_q - in_data_i.data_byte;
      job_o.last_pos = (bytes_left_d == 8'd0) ? POS_POST : POS_DATA;
    end
    job_o.dcs = checksum_d;
  end

  assign job_valid_o = in_acc && has_job;

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= 8'd0;
      checksum_q   <= 8'd0;
      drop_q       <= 1'b0;
    end else if (in_acc) begin
      bytes_left_q <= bytes_left_d;
      checksum_q   <= checksum_d;
      drop_q       <= drop_d;
    end
  end

  // frame identifier register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tfi_q <= TFI_RESET;
    end else if (cfg_we_i) begin
      tfi_q <= cfg_wdata_i;
    end
  end

  // a dropped frame never has payload bytes outstanding
  a_drop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> bytes_left_q == 8'd0)
    else $error("dropping frame with bytes outstanding");

  // an error job is always a single result
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && job_o.first_pos == POS_ERR |-> job_o.last_pos == POS_ERR)
    else $error("error job spans more than one result");

endmodule

>>> hdl/nfc_fb_seq.sv
// ----------------------------------------------------------------------------
// nfc_fb_seq: result sequencer and output register
// Holds one job, walks its byte positions one per cycle while the output is
// not stalled, and loads each result byte into the output register.
// ----------------------------------------------------------------------------
module nfc_fb_seq import nfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  input  nfc_job_t job_i,
  output logic     job_ready_o,
  output logic     out_valid_o,
  output nfc_out_t out_data_o,
  input  logic     out_stall_i
);

  nfc_job_t job_q;
  logic     job_valid_q;
  nfc_pos_e pos_q, pos_d;
  nfc_out_t out_q, out_d;
  logic     out_valid_q;
  logic     out_load;
  logic     emit;
  logic     pop;
  logic     last;

  assign out_load    = !out_valid_q || !out_stall_i;
  assign emit        = job_valid_q && out_load;
  assign last        = pos_q == job_q.last_pos;
  assign pop         = emit && last;
  assign job_ready_o = !job_valid_q || pop;

  // next position
  always_comb begin
    pos_d = pos_q;
    if (job_valid_i && job_ready_o) begin
      pos_d = job_i.first_pos;
    end else if (emit && !last) begin
      pos_d = nfc_pos_e'(pos_q + 4'd1);
    end
  end

  // result byte for the current position
  always_comb begin
    out_d          = '0;
    out_d.run_last = last;
    case (pos_q)
      POS_PRE0, POS_PRE1: out_d.out_byte = PREAMBLE;
      POS_START:          out_d.out_byte = START_CODE;
      POS_LEN:            out_d.out_byte = job_q.len_byte;
      POS_LCS:            out_d.out_byte = 8'd0 - job_q.len_byte;
      POS_TFI:            out_d.out_byte = job_q.tfi;
      POS_DATA:           out_d.out_byte = job_q.data_byte;
      POS_DCS:            out_d.out_byte = job_q.dcs;
      POS_POST: begin
        out_d.out_byte  = POSTAMBLE;
        out_d.frame_end = 1'b1;
      end
      POS_ERR: begin
        out_d.out_byte  = ERR_BYTE;
        out_d.status    = 1'b1;
        out_d.frame_end = 1'b1;
      end
      default:            out_d.out_byte = ERR_BYTE;
    endcase
  end

  // job register and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      pos_q       <= POS_PRE0;
    end else begin
      pos_q <= pos_d;
      if (job_valid_i && job_ready_o) begin
        job_valid_q <= 1'b1;
      end else if (pop) begin
        job_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      job_q <= job_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // position never runs past the end of its job
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> pos_q <= job_q.last_pos)
    else $error("sequencer position beyond job end");

  // the closing byte of a frame ends its run
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_end |-> out_q.run_last)
    else $error("frame end not on last result of its item");

  // a stalled output freezes the sequencer
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && job_valid_q |=> $stable(pos_q) && job_valid_q)
    else $error("sequencer advanced under output stall");

endmodule

>>> hdl/nfc_host_frame_builder.sv
// ----------------------------------------------------------------------------
// nfc_host_frame_builder: normal information frame builder, host direction
// Wraps a command payload, one byte per input transfer, in a normal frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one payload byte
//   per transfer; start_of_frame marks the first byte and carries the length.
//   Output channel (out_valid_o / out_stall_i / out_data_o) gives the framed
//   byte stream; run_last flags the last byte caused by one input transfer.
//   cfg_we_i / cfg_wdata_i write the TFI byte; it is sampled when a frame
//   starts, so write it between frames.
//   The first result of an input transfer passes through the job register
//   and then the output register. The sequencer emits one result byte per
//   cycle while the output is not stalled. An input transfer causes 1 result
//   for a pass-through byte, 3 for the last byte (data, DCS, postamble), 7 or
//   9 for a start byte and 1 for a too-long start; other bytes cause none.
//   Reset clears the frame state and the output, and sets TFI to 0xD4.
//   When the receiver stalls, the output byte holds and the input channel
//   stalls once the one-job buffer is full.
// ----------------------------------------------------------------------------
module nfc_host_frame_builder import nfc_pkg::*; #(
  parameter int MaxPayload = 254
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  nfc_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output nfc_out_t   out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic     job_valid;
  logic     job_ready;
  nfc_job_t job;

  assign in_stall_o = !job_ready;

  // frame state and job builder
  nfc_fb_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_ready_i (job_ready),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  // result sequencer
  nfc_fb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
